>>> design/cei_pkg.sv
// Shared constants for the cubic equivalent index generator.
package cei_pkg;

  // Components in one index triple.
  localparam int unsigned NUM_COMP = 3;

  // Entries in the queue between the classifying front and the emitting back.
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

>>> design/cei_front.sv
// Front end: takes magnitudes of the three components and sorts them ascending.
module cei_front
  import cei_pkg::*;
#(
  parameter int unsigned INDEX_WIDTH = 8
) (
  input  logic signed [INDEX_WIDTH-1:0]               index_a,
  input  logic signed [INDEX_WIDTH-1:0]               index_b,
  input  logic signed [INDEX_WIDTH-1:0]               index_c,
  output logic        [NUM_COMP-1:0][INDEX_WIDTH-2:0] sorted
);

  localparam int unsigned MW = INDEX_WIDTH - 1;

  logic [NUM_COMP-1:0][INDEX_WIDTH-1:0] raw;
  logic [NUM_COMP-1:0][MW-1:0]          mag;
  logic [NUM_COMP-1:0][MW-1:0]          s1;
  logic [NUM_COMP-1:0][MW-1:0]          s2;
  logic [NUM_COMP-1:0][MW-1:0]          s3;
  logic [INDEX_WIDTH-1:0]               neg;

  // Magnitude; the most negative code saturates to the positive maximum.
  always_comb begin
    raw[0] = index_a;
    raw[1] = index_b;
    raw[2] = index_c;
    neg    = '0;
    for (int i = 0; i < NUM_COMP; i++) begin
      neg = -raw[i];
      if (raw[i][INDEX_WIDTH-1]) begin
        if (raw[i][MW-1:0] == '0) begin
          mag[i] = '1;
        end else begin
          mag[i] = neg[MW-1:0];
        end
      end else begin
        mag[i] = raw[i][MW-1:0];
      end
    end
  end

  // Three compare-exchange steps.
  always_comb begin
    s1 = mag;
    if (mag[0] > mag[1]) begin
      s1[0] = mag[1];
      s1[1] = mag[0];
    end
    s2 = s1;
    if (s1[1] > s1[2]) begin
      s2[1] = s1[2];
      s2[2] = s1[1];
    end
    s3 = s2;
    if (s2[0] > s2[1]) begin
      s3[0] = s2[1];
      s3[1] = s2[0];
    end
  end

  assign sorted = s3;

endmodule

>>> design/cei_queue.sv
// Small register queue between the front and back ends.
module cei_queue
  import cei_pkg::*;
#(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/cei_back.sv
// Back end: walks permutations and sign variants, one result per cycle unless the output stalls.
module cei_back
  import cei_pkg::*;
#(
  parameter int unsigned INDEX_WIDTH = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      pop_valid,
  output logic                                      pop_ready,
  input  logic        [NUM_COMP-1:0][INDEX_WIDTH-2:0] pop_data,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [INDEX_WIDTH-1:0]             out_a,
  output logic signed [INDEX_WIDTH-1:0]             out_b,
  output logic signed [INDEX_WIDTH-1:0]             out_c,
  output logic                                      last
);

  localparam int unsigned MW = INDEX_WIDTH - 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [NUM_COMP-1:0][MW-1:0] perm;
  logic [NUM_COMP-1:0][MW-1:0] perm_succ;
  logic [1:0]                  variant;
  logic [1:0]                  variant_max;
  logic [1:0]                  nz_count;
  logic [1:0]                  load_nz;
  logic                        has_succ;
  logic                        is_final;
  logic                        advance;
  logic                        do_pop;
  logic                        neg_b;
  logic                        neg_c;
  logic [INDEX_WIDTH-1:0]      val_a;
  logic [INDEX_WIDTH-1:0]      val_b;
  logic [INDEX_WIDTH-1:0]      val_c;

  // Lexicographic successor of the current permutation.
  always_comb begin
    perm_succ = perm;
    has_succ  = 1'b1;
    if (perm[1] < perm[2]) begin
      perm_succ[1] = perm[2];
      perm_succ[2] = perm[1];
    end else if (perm[0] < perm[1]) begin
      if (perm[2] > perm[0]) begin
        perm_succ[0] = perm[2];
        perm_succ[1] = perm[0];
        perm_succ[2] = perm[1];
      end else begin
        perm_succ[0] = perm[1];
        perm_succ[1] = perm[2];
        perm_succ[2] = perm[0];
      end
    end else begin
      has_succ = 1'b0;
    end
  end

  always_comb begin
    load_nz = 2'd0;
    for (int i = 0; i < NUM_COMP; i++) begin
      load_nz = load_nz + {1'b0, (pop_data[i] != '0)};
    end
  end

  always_comb begin
    unique case (nz_count)
      2'd3:    variant_max = 2'd3;
      2'd2:    variant_max = 2'd1;
      default: variant_max = 2'd0;
    endcase
  end

  assign is_final  = (variant == variant_max) && !has_succ;
  assign advance   = (state == ST_RUN) && (!out_valid || out_ready);
  assign pop_ready = (state == ST_IDLE) || (advance && is_final);
  assign do_pop    = pop_valid && pop_ready;

  // Sign pattern of the current variant.
  always_comb begin
    neg_b = 1'b0;
    neg_c = 1'b0;
    if (nz_count == 2'd3) begin
      neg_b = (variant == 2'd2) || (variant == 2'd3);
      neg_c = (variant == 2'd1) || (variant == 2'd2);
    end else if (nz_count == 2'd2 && variant == 2'd1) begin
      // the later of the two nonzero entries
      neg_c = (perm[2] != '0);
      neg_b = (perm[2] == '0);
    end
  end

  always_comb begin
    val_a = {1'b0, perm[0]};
    val_b = neg_b ? -{1'b0, perm[1]} : {1'b0, perm[1]};
    val_c = neg_c ? -{1'b0, perm[2]} : {1'b0, perm[2]};
  end

  always_comb begin
    state_next = state;
    if (do_pop) begin
      state_next = ST_RUN;
    end else if (advance && is_final) begin
      state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      perm     <= pop_data;
      nz_count <= load_nz;
      variant  <= 2'd0;
    end else if (advance) begin
      if (variant == variant_max) begin
        perm    <= perm_succ;
        variant <= 2'd0;
      end else begin
        variant <= variant + 2'd1;
      end
    end
    if (advance) begin
      out_a <= val_a;
      out_b <= val_b;
      out_c <= val_c;
      last  <= is_final;
    end
  end

endmodule

>>> design/cubic_equivalent_index_generator_core.sv
// Top level of the cubic equivalent index generator: front, queue and back.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  index_a, index_b, index_c
//   out      output     out_valid/out_ready  out_a, out_b, out_c, last
//
// Each input item yields 1 to 24 result items, one per cycle while out_ready
// is high; the back end's permutation/sign walker sets that rate.
// An accepted item passes the queue, the back end's perm register and the
// output register; the next item's walk starts with no gap if it is queued.
// The front accepts whenever the 2-entry queue has room, also while the
// output is stalled. rst is synchronous; it empties the queue and output.
module cubic_equivalent_index_generator_core
  import cei_pkg::*;
#(
  parameter int unsigned INDEX_WIDTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [INDEX_WIDTH-1:0] index_a,
  input  logic signed [INDEX_WIDTH-1:0] index_b,
  input  logic signed [INDEX_WIDTH-1:0] index_c,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [INDEX_WIDTH-1:0] out_a,
  output logic signed [INDEX_WIDTH-1:0] out_b,
  output logic signed [INDEX_WIDTH-1:0] out_c,
  output logic                          last
);

  localparam int unsigned MW = INDEX_WIDTH - 1;
  localparam int unsigned QW = NUM_COMP * MW;

  logic [NUM_COMP-1:0][MW-1:0] sorted;
  logic [NUM_COMP-1:0][MW-1:0] head;
  logic [QW-1:0]               head_flat;
  logic                        q_valid;
  logic                        q_ready;

  // Magnitudes sorted ascending; the walk starts from this order.
  cei_front #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_front (
    .index_a(index_a),
    .index_b(index_b),
    .index_c(index_c),
    .sorted (sorted)
  );

  cei_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(in_valid),
    .push_ready(in_ready),
    .push_data (sorted),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (head_flat)
  );

  assign head = head_flat;

  // Emits every permutation and its sign variants; last marks the end.
  cei_back #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(q_valid),
    .pop_ready(q_ready),
    .pop_data (head),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_a    (out_a),
    .out_b    (out_b),
    .out_c    (out_c),
    .last     (last)
  );

endmodule

>>> design/cei_checker.sv
// Port-level checks for the cubic equivalent index generator, bound to the top.
module cei_checker #(
  parameter int unsigned INDEX_WIDTH = 8
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [INDEX_WIDTH-1:0] out_a,
  input logic signed [INDEX_WIDTH-1:0] out_b,
  input logic signed [INDEX_WIDTH-1:0] out_c,
  input logic                          last
);

  localparam logic [INDEX_WIDTH-1:0] MOST_NEG = {1'b1, {(INDEX_WIDTH-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_a) && $stable(out_b) && $stable(out_c)
      && $stable(last))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not empty after reset");

  a_no_most_neg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_a != MOST_NEG && out_b != MOST_NEG && out_c != MOST_NEG)
    else $error("result holds the most negative code");

  a_first_positive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_a[INDEX_WIDTH-1])
    else $error("first component negative");

endmodule

bind cubic_equivalent_index_generator_core cei_checker #(
  .INDEX_WIDTH(INDEX_WIDTH)
) u_cei_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_a    (out_a),
  .out_b    (out_b),
  .out_c    (out_c),
  .last     (last)
);
